[src/cds_pkg.sv]
// cds_pkg: shared types, codes and calendar constants for the date stepper.
// No dependencies; imported by every module in src.
package cds_pkg;

    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_ADV  = 2'd1;
    localparam logic [1:0] MODE_LOOK = 2'd2;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] FEB_LEAP    = 5'd29;
    localparam logic [4:0] RES_MOD     = 5'd25;   // 100 = 4 * 25, 400 = 16 * 25

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESID,
        ST_CLAMP,
        ST_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
    } t_res_stat;

    // Common-year month length; codes outside 1..12 read as 31.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[src/cds_residue.sv]
// cds_residue: year mod 25; fold on 2^10 = -1 (mod 25), then
// reciprocal multiply for the quotient and subtract. Depends on cds_pkg.
module cds_residue #(
    parameter int YEAR_BITS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [YEAR_BITS-1:0]   i_value,
    output logic [4:0]             o_rem,
    output cds_pkg::t_res_stat     o_stat
);
    import cds_pkg::*;

    // 82 * 25: keeps the folded sum positive without changing it mod 25
    localparam logic [12:0] FOLD_BIAS   = 13'd2050;
    // ceil(2^18 / 25): exact 8-bit quotient for every folded value below 6400
    localparam logic [13:0] RECIP_25    = 14'd10486;
    localparam int          RECIP_SHIFT = 18;
    localparam logic [1:0]  STAGE_QUOT  = 2'd2;
    localparam logic [1:0]  STAGE_REM   = 2'd1;

    logic [39:0] year_ext;
    logic [12:0] fold;
    logic [7:0]  quot;
    logic [4:0]  rem_val;

    logic [12:0] r_v;
    logic [7:0]  r_q;
    logic [4:0]  r_rem;
    logic [1:0]  r_cnt;

    // 10-bit chunks weigh +1, -1, +1, -1 mod 25; result stays in 4..4096
    always_comb begin
        year_ext = 40'(i_value);
        fold     = 13'(year_ext[9:0]) + 13'(year_ext[29:20]) + FOLD_BIAS
                   - 13'(year_ext[19:10]) - 13'(year_ext[39:30]);
    end

    always_comb begin
        quot    = 8'((27'(r_v) * 27'(RECIP_25)) >> RECIP_SHIFT);
        rem_val = 5'(r_v - 13'(r_q) * 13'(RES_MOD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STAGE_QUOT;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= fold;
        end
        if (r_cnt == STAGE_QUOT) begin
            r_q <= quot;
        end
        if (r_cnt == STAGE_REM) begin
            r_rem <= rem_val;
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = (r_cnt != '0);

endmodule

[src/cds_next_day.sv]
// cds_next_day: one-day calendar step and month length for a working date.
// Depends on cds_pkg. Leap test uses year bits plus year mod 25.
module cds_next_day #(
    parameter int YEAR_BITS = 14
) (
    input  logic [4:0]           i_day,
    input  logic [3:0]           i_month,
    input  logic [YEAR_BITS-1:0] i_year,
    input  logic [4:0]           i_m25,
    output logic [4:0]           o_day,
    output logic [3:0]           o_month,
    output logic [YEAR_BITS-1:0] o_year,
    output logic [4:0]           o_m25,
    output logic [4:0]           o_len
);
    import cds_pkg::*;

    logic leap;

    // div by 400 <=> div by 16 and 25; div by 4 but not 100 <=> div by 4, not 25
    assign leap = ((i_year[1:0] == 2'b00) && (i_m25 != 5'd0)) ||
                  ((i_year[3:0] == 4'b0000) && (i_m25 == 5'd0));

    always_comb begin
        o_len = month_len(i_month);
        if ((i_month == MONTH_FEB) && leap) begin
            o_len = FEB_LEAP;
        end
    end

    always_comb begin
        o_day   = i_day + 5'd1;
        o_month = i_month;
        o_year  = i_year;
        o_m25   = i_m25;
        if (i_day >= o_len) begin
            o_day = DAY_FIRST;
            if (i_month >= MONTH_LAST) begin
                o_month = MONTH_FIRST;
                o_year  = i_year + 1'b1;
                if ((&i_year) || (i_m25 == RES_MOD - 5'd1)) begin
                    o_m25 = 5'd0;   // wrap to year 0, or residue rollover
                end else begin
                    o_m25 = i_m25 + 5'd1;
                end
            end else begin
                o_month = i_month + 4'd1;
            end
        end
    end

endmodule

[src/calendar_date_stepper_core.sv]
// calendar_date_stepper_core: top level of the Gregorian date stepper.
// Depends on cds_pkg, cds_residue, cds_next_day.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction: mode,
//   requested day/month/year and a day count. Output channel
//   (o_out_valid / i_out_ready) returns exactly one result per transaction:
//   the resulting date and the date held before it.
//   Modes: set loads a clamped date, advance moves the held date forward by
//   the count, look-ahead reports held date plus count without storing it.
//   Any other mode code returns the held date unchanged.
// Timing:
//   Advance / look-ahead: the working date steps one day per cycle through
//   the shared next-day step until the count is used up, then the result.
//   Set: the year mod 25 unit that feeds the leap-year test runs first,
//   then residue load, day clamp, result.
//   One transaction is in flight at a time; o_in_ready is high while idle.
// Reset: synchronous, active low; held date becomes 1 January, year 0,
//   output register empty.
// Stall: the result sits in an output register; a new transaction may be
//   accepted while it waits, and that one finishes once the register frees.
module calendar_date_stepper_core #(
    parameter int YEAR_BITS  = 14,
    parameter int COUNT_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [5:0]             i_day_in,
    input  logic [3:0]             i_month_in,
    input  logic [YEAR_BITS-1:0]   i_year_in,
    input  logic [COUNT_BITS-1:0]  i_day_count,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [4:0]             o_day_out,
    output logic [3:0]             o_month_out,
    output logic [YEAR_BITS-1:0]   o_year_out,
    output logic [4:0]             o_before_day,
    output logic [3:0]             o_before_month,
    output logic [YEAR_BITS-1:0]   o_before_year
);
    import cds_pkg::*;

    t_state r_state, n_state;

    // held date plus its year mod 25
    logic [4:0]           r_cur_day;
    logic [3:0]           r_cur_month;
    logic [YEAR_BITS-1:0] r_cur_year;
    logic [4:0]           r_cur_m25;

    // working date for the transaction in flight
    logic [4:0]           r_w_day;
    logic [3:0]           r_w_month;
    logic [YEAR_BITS-1:0] r_w_year;
    logic [4:0]           r_w_m25;
    logic [5:0]           r_req_day;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                 r_commit;

    // output register
    logic                 r_out_valid;
    logic [4:0]           r_o_day;
    logic [3:0]           r_o_month;
    logic [YEAR_BITS-1:0] r_o_year;
    logic [4:0]           r_o_bday;
    logic [3:0]           r_o_bmonth;
    logic [YEAR_BITS-1:0] r_o_byear;

    logic                 in_fire;
    logic                 out_free;
    logic                 res_start;
    logic [4:0]           res_rem;
    t_res_stat            res_stat;

    logic [4:0]           nd_day;
    logic [3:0]           nd_month;
    logic [YEAR_BITS-1:0] nd_year;
    logic [4:0]           nd_m25;
    logic [4:0]           nd_len;

    logic [3:0]           req_month;
    logic [4:0]           clamp_day;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign res_start = in_fire && (i_mode == MODE_SET);

    cds_residue #(
        .YEAR_BITS (YEAR_BITS)
    ) u_residue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (res_start),
        .i_value (i_year_in),
        .o_rem   (res_rem),
        .o_stat  (res_stat)
    );

    // the one calendar step, reused for every day and for the set clamp
    cds_next_day #(
        .YEAR_BITS (YEAR_BITS)
    ) u_next_day (
        .i_day   (r_w_day),
        .i_month (r_w_month),
        .i_year  (r_w_year),
        .i_m25   (r_w_m25),
        .o_day   (nd_day),
        .o_month (nd_month),
        .o_year  (nd_year),
        .o_m25   (nd_m25),
        .o_len   (nd_len)
    );

    // month clamp to 1..12 on set
    always_comb begin
        if (i_month_in < MONTH_FIRST) begin
            req_month = MONTH_FIRST;
        end else if (i_month_in > MONTH_LAST) begin
            req_month = MONTH_LAST;
        end else begin
            req_month = i_month_in;
        end
    end

    // day clamp to 1..month length, leap included
    always_comb begin
        if (r_req_day == 6'd0) begin
            clamp_day = DAY_FIRST;
        end else if (r_req_day > {1'b0, nd_len}) begin
            clamp_day = nd_len;
        end else begin
            clamp_day = r_req_day[4:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (i_mode == MODE_SET) begin
                        n_state = ST_RESID;
                    end else if (i_mode == MODE_ADV || i_mode == MODE_LOOK) begin
                        n_state = ST_STEP;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_RESID: begin
                if (!res_stat.busy) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: n_state = ST_FINISH;
            ST_STEP: begin
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_commit  <= (i_mode == MODE_SET) || (i_mode == MODE_ADV);
                    r_cnt     <= i_day_count;
                    r_req_day <= i_day_in;
                    if (i_mode == MODE_SET) begin
                        r_w_day   <= DAY_FIRST;
                        r_w_month <= req_month;
                        r_w_year  <= i_year_in;
                        r_w_m25   <= 5'd0;
                    end else begin
                        r_w_day   <= r_cur_day;
                        r_w_month <= r_cur_month;
                        r_w_year  <= r_cur_year;
                        r_w_m25   <= r_cur_m25;
                    end
                end
            end
            ST_RESID: begin
                if (!res_stat.busy) begin
                    r_w_m25 <= res_rem;
                end
            end
            ST_CLAMP: begin
                r_w_day <= clamp_day;
            end
            ST_STEP: begin
                if (r_cnt != '0) begin
                    r_w_day   <= nd_day;
                    r_w_month <= nd_month;
                    r_w_year  <= nd_year;
                    r_w_m25   <= nd_m25;
                    r_cnt     <= r_cnt - 1'b1;
                end
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // held date: committed when the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day   <= DAY_FIRST;
            r_cur_month <= MONTH_FIRST;
            r_cur_year  <= '0;
            r_cur_m25   <= 5'd0;
        end else if ((r_state == ST_FINISH) && out_free && r_commit) begin
            r_cur_day   <= r_w_day;
            r_cur_month <= r_w_month;
            r_cur_year  <= r_w_year;
            r_cur_m25   <= r_w_m25;
        end
    end

    // output register; before-date is the held date not yet overwritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && out_free) begin
            r_o_day    <= r_w_day;
            r_o_month  <= r_w_month;
            r_o_year   <= r_w_year;
            r_o_bday   <= r_cur_day;
            r_o_bmonth <= r_cur_month;
            r_o_byear  <= r_cur_year;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_day_out      = r_o_day;
    assign o_month_out    = r_o_month;
    assign o_year_out     = r_o_year;
    assign o_before_day   = r_o_bday;
    assign o_before_month = r_o_bmonth;
    assign o_before_year  = r_o_byear;

endmodule
